// File: rtl/tvm_pkg.sv
package tvm_pkg;

    // command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_POLL    = 2'd1,
        CMD_OBSERVE = 2'd2,
        CMD_CANCEL  = 2'd3
    } cmd_t;

    // observe report codes
    typedef enum logic [1:0] {
        VER_DIVERGED = 2'd0,
        VER_NEED     = 2'd1,
        VER_STABLE   = 2'd2,
        VER_INVALID  = 2'd3
    } ver_t;

    // monitor state and returned status share one encoding
    typedef enum logic [2:0] {
        ST_INACTIVE  = 3'd0,
        ST_WAITING   = 3'd1,
        ST_STABLE    = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_BUDGET    = 3'd4,
        ST_BADCLOCK  = 3'd5,
        ST_BADVERIFY = 3'd6,
        ST_BADID     = 3'd7
    } status_t;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_BUDGET  = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
    localparam logic [7:0]  BUDGET_RESET  = 8'd3;
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;

    // one result item
    typedef struct packed {
        status_t status;
        logic    accepted;
    } tvm_result_t;

endpackage

// File: rtl/tvm_core.sv
module tvm_core
    import tvm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  cmd_t        cmd,
    input  logic [63:0] transaction_id,
    input  logic [63:0] now_ms,
    input  ver_t        verification,
    input  logic [31:0] timeout_ms,
    input  logic [7:0]  divergence_budget,
    output tvm_result_t result,
    output status_t     state
);

    logic [63:0] active_id_reg,  active_id_next;
    logic [63:0] start_time_reg, start_time_next;
    logic [63:0] last_time_reg,  last_time_next;
    logic [7:0]  count_reg,      count_next;
    status_t     state_reg,      state_next;

    logic        id_nonzero;
    logic        id_ok;
    logic        clock_bad;
    logic        timed_out;
    logic [63:0] elapsed;
    logic [7:0]  count_inc;
    status_t     check_state;
    logic        accepted;
    status_t     status;

    // shared checks against the registered state
    assign id_nonzero = (transaction_id != 64'd0);
    assign id_ok      = id_nonzero && (transaction_id == active_id_reg);
    assign clock_bad  = (now_ms < last_time_reg);
    assign elapsed    = now_ms - start_time_reg;
    assign timed_out  = (elapsed >= {32'd0, timeout_ms});
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;

    // state after the time check
    always_comb begin
        if (clock_bad) begin
            check_state = ST_BADCLOCK;
        end else if (timed_out) begin
            check_state = ST_TIMEOUT;
        end else begin
            check_state = state_reg;
        end
    end

    // next state and status for one command
    always_comb begin
        active_id_next  = active_id_reg;
        start_time_next = start_time_reg;
        last_time_next  = last_time_reg;
        count_next      = count_reg;
        state_next      = state_reg;
        accepted        = 1'b0;
        status          = state_reg;
        case (cmd)
            CMD_BEGIN: begin
                if (id_nonzero && state_reg == ST_INACTIVE) begin
                    active_id_next  = transaction_id;
                    start_time_next = now_ms;
                    last_time_next  = now_ms;
                    count_next      = 8'd0;
                    state_next      = ST_WAITING;
                    accepted        = 1'b1;
                end
                status = state_next;
            end
            CMD_POLL: begin
                if (!id_ok) begin
                    status = ST_BADID;
                end else begin
                    if (state_reg == ST_WAITING || state_reg == ST_STABLE) begin
                        state_next = check_state;
                        if (!clock_bad) begin
                            last_time_next = now_ms;
                        end
                    end
                    status = state_next;
                end
            end
            CMD_OBSERVE: begin
                if (!id_ok) begin
                    status = ST_BADID;
                end else begin
                    if (state_reg == ST_WAITING) begin
                        state_next = check_state;
                        if (!clock_bad) begin
                            last_time_next = now_ms;
                        end
                        // report only counts while still waiting
                        if (check_state == ST_WAITING) begin
                            case (verification)
                                VER_DIVERGED: begin
                                    count_next = count_inc;
                                    if (count_inc >= divergence_budget) begin
                                        state_next = ST_BUDGET;
                                    end
                                end
                                VER_STABLE:  state_next = ST_STABLE;
                                VER_INVALID: state_next = ST_BADVERIFY;
                                default:     state_next = check_state;
                            endcase
                        end
                    end
                    status = state_next;
                end
            end
            default: begin
                if (id_ok) begin
                    active_id_next  = 64'd0;
                    start_time_next = 64'd0;
                    last_time_next  = 64'd0;
                    count_next      = 8'd0;
                    state_next      = ST_INACTIVE;
                end
                status = state_next;
            end
        endcase
    end

    // state registers, updated once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_id_reg  <= 64'd0;
            start_time_reg <= 64'd0;
            last_time_reg  <= 64'd0;
            count_reg      <= 8'd0;
            state_reg      <= ST_INACTIVE;
        end else if (fire) begin
            active_id_reg  <= active_id_next;
            start_time_reg <= start_time_next;
            last_time_reg  <= last_time_next;
            count_reg      <= count_next;
            state_reg      <= state_next;
        end
    end

    assign result.status   = status;
    assign result.accepted = accepted;
    assign state           = state_reg;

endmodule

// File: rtl/transaction_verify_monitor.sv
// channel   dir  ports                          contents
// request   in   s_tvalid s_tready s_tdata      id, now_ms, verification
//                s_tuser                        cmd
// result    out  m_tvalid m_tready m_tdata      status, accepted
// config    in   cfg_we cfg_index cfg_wdata     timeout_ms, divergence_budget
//
// one request per cycle sustained while m_tready is high; a request passes
// the input register, then the result register, on its way to m_tvalid; the
// state update reads the registered state and writes it as the result loads.
// aresetn is synchronous active low and clears state and valids; config
// returns to its reset values.
// the input register holds a request while the result register is stalled.
module transaction_verify_monitor
    import tvm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // transaction_id, now_ms, verification, zero pad
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // status, accepted, zero pad
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);

    logic        in_valid_reg;
    cmd_t        cmd_reg;
    logic [63:0] id_reg;
    logic [63:0] now_reg;
    ver_t        ver_reg;

    logic        out_valid_reg;
    tvm_result_t out_reg;

    logic [31:0] timeout_reg;
    logic [7:0]  budget_reg;

    logic        fire;
    tvm_result_t result;
    status_t     state;

    // request moves into the result register when that one is free
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            budget_reg  <= BUDGET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                CFG_BUDGET:  budget_reg  <= cfg_wdata[7:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_t'(s_tuser);
            id_reg  <= s_tdata[63:0];
            now_reg <= s_tdata[127:64];
            ver_reg <= ver_t'(s_tdata[129:128]);
        end
    end

    tvm_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fire              (fire),
        .cmd               (cmd_reg),
        .transaction_id    (id_reg),
        .now_ms            (now_reg),
        .verification      (ver_reg),
        .timeout_ms        (timeout_reg),
        .divergence_budget (budget_reg),
        .result            (result),
        .state             (state)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.accepted, out_reg.status};

`ifndef NO_ASSERTIONS
    // an accepted begin always reports the waiting state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[2:0] == ST_WAITING))
        else $error("accepted begin without waiting status");

    // bad id is only a returned status, never held
    assert property (@(posedge aclk) disable iff (!aresetn)
        state != ST_BADID)
        else $error("monitor state holds bad id");

    // a request moved forward shows up as a valid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("request lost between stages");

    // back pressure only with a request parked in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule
